// File: hw/rtl/pdr_pkg.sv
// Shared types and constants for the planar dead-reckoning update block.
`default_nettype none
package pdr_pkg;

  localparam int unsigned AtanEntries = 24;
  localparam int unsigned ZW = 20;  // CORDIC angle width, Q.16 rad
  localparam int unsigned XW = 19;  // CORDIC x/y width, Q.16
  localparam logic signed [ZW-1:0] PiQ16 = 20'sd205887;
  localparam logic signed [ZW-1:0] HalfPiQ16 = 20'sd102944;
  localparam logic signed [XW-1:0] CordicGain = 19'sd39797;

  localparam logic [1:0] RegGravity = 2'd0;
  localparam logic [1:0] RegLeak = 2'd1;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic [15:0] time_step;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [47:0] position_x;
    logic signed [47:0] position_y;
  } out_item_t;

  // datapath operations, one per controller step
  typedef enum logic [3:0] {
    OpLoad,     // latch item, fold angles, init CORDIC
    OpCordic,   // one rotation on both angles
    OpFinish,   // apply half-turn negation
    OpGravity,  // g*ax, g*ay, g*sin_p, g*cos_p
    OpLinY,     // (g*cos_p>>16)*sin_r, form lin_x
    OpVelInt,   // lin*dt
    OpVelAdd,   // v += ..., saturate
    OpLeak,     // v*leak
    OpLeakSat,  // saturate
    OpPosMul,   // v*dt
    OpPosAdd    // p += ..., saturate
  } op_e;

  typedef struct packed {
    logic en;
    op_e op;
    logic [4:0] iter;
  } dp_cmd_t;

  function automatic logic [16:0] atan_q16(input logic [4:0] i);
    logic [16:0] r;
    case (i)
      5'd0: r = 17'd51472;
      5'd1: r = 17'd30385;
      5'd2: r = 17'd16055;
      5'd3: r = 17'd8150;
      5'd4: r = 17'd4091;
      5'd5: r = 17'd2047;
      5'd6: r = 17'd1024;
      5'd7: r = 17'd512;
      5'd8: r = 17'd256;
      5'd9: r = 17'd128;
      5'd10: r = 17'd64;
      5'd11: r = 17'd32;
      5'd12: r = 17'd16;
      5'd13: r = 17'd8;
      5'd14: r = 17'd4;
      5'd15: r = 17'd2;
      5'd16: r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/pdr_ctrl.sv
// Sequencer for the dead-reckoning update: handshakes and datapath steps.
`default_nettype none
module pdr_ctrl #(
  parameter int unsigned Iterations = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output pdr_pkg::dp_cmd_t cmd_o
);

  localparam int unsigned NIter = (Iterations > pdr_pkg::AtanEntries) ?
      pdr_pkg::AtanEntries : Iterations;
  localparam logic [4:0] LastIter = 5'(NIter - 1);

  typedef enum logic [3:0] {
    StIdle, StCordic, StFinish, StGrav, StLinY, StVelInt, StVelAdd,
    StLeak, StLeakSat, StPosMul, StPosAdd, StOut
  } state_e;

  state_e state_q;
  logic [4:0] iter_q;
  logic out_valid_q;

  // an item is taken in idle when the result slot is empty or drains this cycle
  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.en = 1'b1;
    cmd_o.iter = iter_q;
    cmd_o.op = pdr_pkg::OpLoad;
    unique case (state_q)
      StIdle: begin
        cmd_o.en = in_valid_i && in_ready_o;
        cmd_o.op = pdr_pkg::OpLoad;
      end
      StCordic: cmd_o.op = pdr_pkg::OpCordic;
      StFinish: cmd_o.op = pdr_pkg::OpFinish;
      StGrav: cmd_o.op = pdr_pkg::OpGravity;
      StLinY: cmd_o.op = pdr_pkg::OpLinY;
      StVelInt: cmd_o.op = pdr_pkg::OpVelInt;
      StVelAdd: cmd_o.op = pdr_pkg::OpVelAdd;
      StLeak: cmd_o.op = pdr_pkg::OpLeak;
      StLeakSat: cmd_o.op = pdr_pkg::OpLeakSat;
      StPosMul: cmd_o.op = pdr_pkg::OpPosMul;
      StPosAdd: cmd_o.op = pdr_pkg::OpPosAdd;
      default: cmd_o.en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      iter_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (in_valid_i && in_ready_o) begin
            state_q <= StCordic;
            iter_q <= '0;
          end
        end
        StCordic: begin
          if (iter_q == LastIter) state_q <= StFinish;
          else iter_q <= iter_q + 5'd1;
        end
        StFinish: state_q <= StGrav;
        StGrav: state_q <= StLinY;
        StLinY: state_q <= StVelInt;
        StVelInt: state_q <= StVelAdd;
        StVelAdd: state_q <= StLeak;
        StLeak: state_q <= StLeakSat;
        StLeakSat: state_q <= StPosMul;
        StPosMul: state_q <= StPosAdd;
        StPosAdd: state_q <= StOut;
        StOut: begin
          // slot is free here: in_ready required it drained or empty
          out_valid_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q != StIdle) |-> !in_ready_o)
    else $error("input taken while busy");
  a_out_after_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_q) |-> $past(state_q == StOut))
    else $error("result raised outside final step");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("result dropped before transfer");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/pdr_datapath.sv
// Datapath: CORDIC for both angles, shared multipliers, integrators.
`default_nettype none
module pdr_datapath (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  pdr_pkg::dp_cmd_t cmd_i,
  input  pdr_pkg::in_item_t in_item_i,
  input  wire logic [19:0] gravity_i,
  input  wire logic [16:0] leak_i,
  output pdr_pkg::out_item_t out_item_o
);

  localparam int unsigned ZW = pdr_pkg::ZW;
  localparam int unsigned XW = pdr_pkg::XW;

  localparam logic signed [31:0] VMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VMin = 32'sh8000_0000;

  // CORDIC state: index 0 roll, 1 pitch
  logic signed [XW-1:0] cx_q [2];
  logic signed [XW-1:0] cy_q [2];
  logic signed [ZW-1:0] cz_q [2];
  logic neg_q [2];

  logic signed [15:0] ax_q, ay_q;
  logic [15:0] dt_q;
  logic signed [XW-1:0] sr_q, sp_q, cp_q;

  // products / intermediates
  logic signed [39:0] lx_q, ly_q;   // lin accel, then lin*dt>>16
  logic signed [39:0] gs_q, gc_q;   // g*sin_p>>16, g*cos_p>>16
  logic signed [31:0] vx_q, vy_q;
  logic signed [47:0] px_q, py_q;
  logic signed [63:0] tx_q, ty_q;   // leak / pos products

  function automatic logic signed [ZW-1:0] fold(input logic signed [15:0] a,
                                                 output logic neg);
    logic signed [ZW-1:0] z;
    z = ZW'(a) <<< 3;
    neg = 1'b0;
    if (z > pdr_pkg::HalfPiQ16) begin
      z = z - pdr_pkg::PiQ16; neg = 1'b1;
    end else if (z < -pdr_pkg::HalfPiQ16) begin
      z = z + pdr_pkg::PiQ16; neg = 1'b1;
    end
    return z;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(VMax)) r = VMax;
    else if (v < 64'(VMin)) r = VMin;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    logic signed [47:0] r;
    if (v[48] != v[47]) r = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    else r = v[47:0];
    return r;
  endfunction

  logic signed [20:0] g_s;
  logic signed [17:0] leak_s;
  logic signed [16:0] dt_s;
  logic signed [ZW-1:0] atn;
  logic signed [ZW-1:0] fz0, fz1;
  logic fn0, fn1;

  assign g_s = {1'b0, gravity_i};
  assign leak_s = {1'b0, leak_i};
  assign dt_s = {1'b0, dt_q};
  assign atn = ZW'(signed'({1'b0, pdr_pkg::atan_q16(cmd_i.iter)}));

  always_comb begin
    fz0 = fold(in_item_i.roll_angle, fn0);
    fz1 = fold(in_item_i.pitch_angle, fn1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_q <= '0;
      vy_q <= '0;
      px_q <= '0;
      py_q <= '0;
    end else if (cmd_i.en) begin
      case (cmd_i.op)
        pdr_pkg::OpVelAdd: begin
          vx_q <= sat32(64'(vx_q) + 64'(lx_q));
          vy_q <= sat32(64'(vy_q) + 64'(ly_q));
        end
        pdr_pkg::OpLeakSat: begin
          vx_q <= sat32(tx_q >>> 16);
          vy_q <= sat32(ty_q >>> 16);
        end
        pdr_pkg::OpPosAdd: begin
          px_q <= sat48(49'(px_q) + 49'(tx_q >>> 16));
          py_q <= sat48(49'(py_q) + 49'(ty_q >>> 16));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.en) begin
      case (cmd_i.op)
        pdr_pkg::OpLoad: begin
          ax_q <= in_item_i.accel_x;
          ay_q <= in_item_i.accel_y;
          dt_q <= in_item_i.time_step;
          cz_q[0] <= fz0;
          cz_q[1] <= fz1;
          neg_q[0] <= fn0;
          neg_q[1] <= fn1;
          for (int k = 0; k < 2; k++) begin
            cx_q[k] <= pdr_pkg::CordicGain;
            cy_q[k] <= '0;
          end
        end
        pdr_pkg::OpCordic: begin
          for (int k = 0; k < 2; k++) begin
            if (cz_q[k] >= 0) begin
              cx_q[k] <= cx_q[k] - (cy_q[k] >>> cmd_i.iter);
              cy_q[k] <= cy_q[k] + (cx_q[k] >>> cmd_i.iter);
              cz_q[k] <= cz_q[k] - atn;
            end else begin
              cx_q[k] <= cx_q[k] + (cy_q[k] >>> cmd_i.iter);
              cy_q[k] <= cy_q[k] - (cx_q[k] >>> cmd_i.iter);
              cz_q[k] <= cz_q[k] + atn;
            end
          end
        end
        pdr_pkg::OpFinish: begin
          sr_q <= neg_q[0] ? -cy_q[0] : cy_q[0];
          sp_q <= neg_q[1] ? -cy_q[1] : cy_q[1];
          cp_q <= neg_q[1] ? -cx_q[1] : cx_q[1];
        end
        pdr_pkg::OpGravity: begin
          lx_q <= 40'((37'(ax_q) * 37'(g_s)) >>> 12);
          ly_q <= 40'((37'(ay_q) * 37'(g_s)) >>> 12);
          gs_q <= 40'((40'(sp_q) * 40'(g_s)) >>> 16);
          gc_q <= 40'((40'(cp_q) * 40'(g_s)) >>> 16);
        end
        pdr_pkg::OpLinY: begin
          lx_q <= lx_q + gs_q;
          ly_q <= ly_q - 40'((48'(gc_q) * 48'(sr_q)) >>> 16);
        end
        pdr_pkg::OpVelInt: begin
          lx_q <= 40'((57'(lx_q) * 57'(dt_s)) >>> 16);
          ly_q <= 40'((57'(ly_q) * 57'(dt_s)) >>> 16);
        end
        pdr_pkg::OpLeak: begin
          tx_q <= 64'(vx_q) * 64'(leak_s);
          ty_q <= 64'(vy_q) * 64'(leak_s);
        end
        pdr_pkg::OpPosMul: begin
          tx_q <= 64'(vx_q) * 64'(dt_s);
          ty_q <= 64'(vy_q) * 64'(dt_s);
        end
        default: ;
      endcase
    end
  end

  assign out_item_o.velocity_x = vx_q;
  assign out_item_o.velocity_y = vy_q;
  assign out_item_o.position_x = px_q;
  assign out_item_o.position_y = py_q;

`ifndef SYNTH
  a_pos_sat_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (cmd_i.en && cmd_i.op == pdr_pkg::OpPosAdd && !tx_q[63]) |=>
      (px_q >= $past(px_q)))
    else $error("x position decreased on non-negative step");
  a_vel_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !cmd_i.en |=> $stable(vx_q) && $stable(vy_q))
    else $error("velocity changed without a command");
  a_pos_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !cmd_i.en |=> $stable(px_q) && $stable(py_q))
    else $error("position changed without a command");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/planar_dead_reckoning_update.sv
// Top level of the planar dead-reckoning update block.
// One item at a time: after a transfer the block runs Iterations CORDIC steps
// (capped at AtanEntries) on roll and pitch together, then nine steps that
// negate, multiply, accumulate and saturate, and then raises the result from
// an output state. The next input is taken once the result register is empty
// or drains in the same cycle.
// Registers: 0x0 gravity_accel (Q4.16), 0x4 velocity_leak (Q1.16).
`default_nettype none
module planar_dead_reckoning_update #(
  parameter int unsigned Iterations = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  pdr_pkg::in_item_t in_item_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output pdr_pkg::out_item_t out_item_o,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  logic [19:0] gravity_q;
  logic [16:0] leak_q;
  pdr_pkg::dp_cmd_t cmd;
  logic [1:0] reg_idx;

  assign pready = 1'b1;
  assign reg_idx = {1'b0, paddr[2]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q <= 20'd642689;
      leak_q <= 17'd65470;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        pdr_pkg::RegGravity: gravity_q <= pwdata[19:0];
        pdr_pkg::RegLeak: leak_q <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pdr_pkg::RegGravity: prdata = {12'd0, gravity_q};
      pdr_pkg::RegLeak: prdata = {15'd0, leak_q};
      default: prdata = '0;
    endcase
  end

  pdr_ctrl #(.Iterations(Iterations)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd)
  );

  pdr_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_item_i, .gravity_i(gravity_q),
    .leak_i(leak_q), .out_item_o
  );

endmodule
`default_nettype wire

// File: bench/pdr_checker.sv
// Checker for the planar dead-reckoning update: predicts each result and compares it.
`default_nettype none
module pdr_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_ready_i,
  input  pdr_pkg::in_item_t in_item_i,
  input  wire logic out_valid_i,
  input  wire logic out_ready_i,
  input  pdr_pkg::out_item_t out_item_i,
  input  wire logic [19:0] gravity_i,
  input  wire logic [16:0] leak_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned results_o
);

  localparam int unsigned Iters = 16;
  localparam longint VelMax = 64'sd2147483647;
  localparam longint VelMin = -64'sd2147483648;
  localparam longint PosMax = 64'sd140737488355327;
  localparam longint PosMin = -64'sd140737488355328;

  longint vel_x, vel_y, pos_x, pos_y;
  pdr_pkg::out_item_t nav_expected[$];

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // folded CORDIC; >>> on longint floors
  task automatic sincos(input logic signed [15:0] ang, output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(ang) * 8;
    x = 39797;
    y = 0;
    flip = 0;
    if (z > 102944) begin
      z -= 205887;
      flip = 1;
    end else if (z < -102944) begin
      z += 205887;
      flip = 1;
    end
    for (int i = 0; i < Iters; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(pdr_pkg::atan_q16(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(pdr_pkg::atan_q16(5'(i)));
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  task automatic predict_nav(input pdr_pkg::in_item_t it, output pdr_pkg::out_item_t r);
    longint sr, cr, sp, cp, g, lk, dt, lx, ly;
    g = longint'(gravity_i);
    lk = longint'(leak_i);
    dt = longint'(it.time_step);
    sincos(it.roll_angle, sr, cr);
    sincos(it.pitch_angle, sp, cp);
    lx = ((longint'(it.accel_x) * g) >>> 12) + ((g * sp) >>> 16);
    ly = ((longint'(it.accel_y) * g) >>> 12) - ((((g * cp) >>> 16) * sr) >>> 16);
    vel_x = clip(vel_x + ((lx * dt) >>> 16), VelMin, VelMax);
    vel_y = clip(vel_y + ((ly * dt) >>> 16), VelMin, VelMax);
    vel_x = clip((vel_x * lk) >>> 16, VelMin, VelMax);
    vel_y = clip((vel_y * lk) >>> 16, VelMin, VelMax);
    pos_x = clip(pos_x + ((vel_x * dt) >>> 16), PosMin, PosMax);
    pos_y = clip(pos_y + ((vel_y * dt) >>> 16), PosMin, PosMax);
    r.velocity_x = vel_x[31:0];
    r.velocity_y = vel_y[31:0];
    r.position_x = pos_x[47:0];
    r.position_y = pos_y[47:0];
  endtask

  assign pending_o = nav_expected.size();

  always @(posedge clk_i or negedge rst_ni) begin
    pdr_pkg::out_item_t e, nx;
    if (!rst_ni) begin
      vel_x = 0; vel_y = 0; pos_x = 0; pos_y = 0;
      nav_expected.delete();
      errors_o <= 0;
      results_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_o <= results_o + 1;
        if (nav_expected.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_item_i);
          errors_o <= errors_o + 1;
        end else begin
          e = nav_expected.pop_front();
          if (e.velocity_x !== out_item_i.velocity_x ||
              e.velocity_y !== out_item_i.velocity_y ||
              e.position_x !== out_item_i.position_x ||
              e.position_y !== out_item_i.position_y) begin
            $display("%0t: mismatch vx exp %0d got %0d, vy exp %0d got %0d", $time,
                     e.velocity_x, out_item_i.velocity_x, e.velocity_y,
                     out_item_i.velocity_y);
            $display("%0t:   px exp %0d got %0d, py exp %0d got %0d", $time,
                     e.position_x, out_item_i.position_x, e.position_y,
                     out_item_i.position_y);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_nav(in_item_i, nx);
        nav_expected.push_back(nx);
      end
    end
  end
endmodule
`default_nettype wire

// File: bench/tb_planar_dead_reckoning_update.sv
// Top of the testbench: stimulus, register writes, watchdog and verdict.
`default_nettype none
module tb_planar_dead_reckoning_update;

  localparam int unsigned StallLimit = 4000;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, out_ready_i = 0;
  pdr_pkg::in_item_t in_item_i = '0;
  logic in_ready_o, out_valid_o;
  pdr_pkg::out_item_t out_item_o;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;

  logic [19:0] gravity_cfg = 20'd642689;
  logic [16:0] leak_cfg = 17'd65470;
  int unsigned errors, pending, results, idle_cycles, sent;
  bit calm;  // no idling on either side

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  planar_dead_reckoning_update DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pdr_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_item_i(out_item_o),
    .gravity_i(gravity_cfg), .leak_i(leak_cfg),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  always @(posedge clk_i) out_ready_i <= calm || ($urandom_range(99) >= 9);

  // watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 1'b0} << 1; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == pdr_pkg::RegGravity) gravity_cfg = val[19:0];
    else if (idx == pdr_pkg::RegLeak) leak_cfg = val[16:0];
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic send(input pdr_pkg::in_item_t it);
    @(posedge clk_i);
    while (!calm && $urandom_range(99) < 9) @(posedge clk_i);
    in_valid_i <= 1;
    in_item_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    in_valid_i <= 0;
    sent++;
  endtask

  function automatic pdr_pkg::in_item_t mk(input int r, input int p, input int ax,
                                           input int ay, input int dt);
    pdr_pkg::in_item_t it;
    it.roll_angle = 16'(r);
    it.pitch_angle = 16'(p);
    it.accel_x = 16'(ax);
    it.accel_y = 16'(ay);
    it.time_step = 16'(dt);
    return it;
  endfunction

  function automatic pdr_pkg::in_item_t rand_item(input bit wild);
    pdr_pkg::in_item_t it;
    it = pdr_pkg::in_item_t'(80'({$urandom, $urandom, $urandom}));
    if (!wild) begin
      it.roll_angle = 16'($urandom_range(51472) - 25736);
      it.pitch_angle = 16'($urandom_range(51472) - 25736);
      it.time_step = 16'($urandom_range(4000));
    end
    return it;
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      send(rand_item($urandom_range(9) < 2));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    // directed: field extremes, angle fold on both sides, beyond-pi angles
    send(mk(0, 0, 0, 0, 0));
    send(mk(25736, 25736, 32767, 32767, 65535));
    send(mk(-25736, -25736, -32768, -32768, 65535));
    send(mk(12868, -12868, 4096, -4096, 655));
    send(mk(-12869, 12869, 0, 0, 655));
    send(mk(32767, -32768, 100, -100, 1000));
    send(mk(-32768, 32767, -100, 100, 1000));
    send(mk(12868, 12868, 32767, 32767, 65535));
    send(mk(-1, 1, -1, 1, 1));
    repeat (10) send(mk(0, 0, 32767, -32768, 65535));  // drive velocity up with full-scale items
    drain();  // sender holds off until all results are in
    random_phase(200);
    drain();
    write_reg(pdr_pkg::RegLeak, 32'd65536);
    write_reg(pdr_pkg::RegGravity, 32'd1048575);
    calm = 1;
    random_phase(200);
    calm = 0;
    repeat (30) send(mk(0, 25736, 32767, 32767, 65535));  // position toward saturation
    drain();
    write_reg(pdr_pkg::RegLeak, 32'd131071);  // leak above one
    write_reg(pdr_pkg::RegGravity, 32'd0);
    random_phase(150);
    drain();
    write_reg(pdr_pkg::RegLeak, 32'd0);
    write_reg(pdr_pkg::RegGravity, 32'd642689);
    random_phase(150);
    drain();
    write_reg(pdr_pkg::RegLeak, 32'd65470);
    write_reg(pdr_pkg::RegGravity, 32'd1);
    random_phase(150);
    drain();
    write_reg(pdr_pkg::RegGravity, 32'd642689);
    random_phase(250);
    drain();
    $display("Sent %0d items, checked %0d results over six register settings.", sent,
             results);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
hw/rtl/pdr_pkg.sv
hw/rtl/pdr_ctrl.sv
hw/rtl/pdr_datapath.sv
hw/rtl/planar_dead_reckoning_update.sv
bench/pdr_checker.sv
bench/tb_planar_dead_reckoning_update.sv
